[design/pfq_pkg.sv]
// Package for the prefetch queue with bus statistics.
// Holds command codes, fixed constants and the transaction payload structs.
// No dependencies.
`default_nettype none

package pfq_pkg;

  // Command codes
  localparam logic [2:0] CMD_ENQ_BYTE = 3'd0;
  localparam logic [2:0] CMD_ENQ_WORD = 3'd1;
  localparam logic [2:0] CMD_DEQ_BYTE = 3'd2;
  localparam logic [2:0] CMD_FLUSH    = 3'd3;
  localparam logic [2:0] CMD_BOUNDARY = 3'd4;
  localparam logic [2:0] CMD_RECORD   = 3'd5;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Every bus transaction takes this many clocks before wait states
  localparam logic [31:0] BUS_BASE_CLOCKS = 32'd4;
  // Bytes taken in by a word enqueue
  localparam int WORD_BYTES = 2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] data;
    logic [7:0]  bus_waits;
    logic        txn_ok;
    logic        demand;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  read_byte;
    logic [2:0]  queue_count;
    logic [2:0]  free_bytes;
    logic [15:0] fetch_ptr;
    logic        flushed;
    logic [31:0] bus_transactions;
    logic [31:0] wait_state_total;
    logic [31:0] bus_active_clocks;
    logic [31:0] demand_transactions;
    logic [31:0] demand_bus_clocks;
    logic [31:0] queue_reads;
  } result_t;

endpackage

`default_nettype wire

[design/prefetch_queue_with_bus_stats_unit.sv]
// Prefetch queue with bus statistics: byte-wide circular queue plus bus counters.
// Depends on pfq_pkg (command codes, constants, item_t and result_t).
`default_nettype none

// One command per clock. A command is captured in an input register when it is
// accepted, then executed against the queue and counter state when the result
// register can advance; its result goes into an output register and is held
// until taken. Throughput is one command per clock; it drops only while the result
// register waits on result_ready. Queue depth is QUEUE_DEPTH bytes (2 to 16);
// queue_count and free_bytes report the low three bits of the counts.
module prefetch_queue_with_bus_stats_unit #(
  parameter int QUEUE_DEPTH = 6
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_ready,
  input  pfq_pkg::item_t        item,
  output logic                  result_valid,
  input  wire                   result_ready,
  output pfq_pkg::result_t      result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int SUM_W = CNT_W + 1;

  // Fold a slot position below twice the depth back into the ring
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] pos);
    logic [SUM_W-1:0] folded;
    folded = (pos >= SUM_W'(QUEUE_DEPTH)) ? (pos - SUM_W'(QUEUE_DEPTH)) : pos;
    return folded[IDX_W-1:0];
  endfunction

  // Input register
  logic           in_full;
  pfq_pkg::item_t in_q;
  logic           advance;
  logic           exec;

  // Queue and counter state
  logic [7:0]       queue_bytes [QUEUE_DEPTH];
  logic [IDX_W-1:0] head_index, head_index_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [15:0]      fetch_address, fetch_address_next;
  logic             flush_mark, flush_mark_next;
  logic [31:0]      txn_count, txn_count_next;
  logic [31:0]      wait_sum, wait_sum_next;
  logic [31:0]      active_clock_sum, active_clock_sum_next;
  logic [31:0]      demand_txn_count, demand_txn_count_next;
  logic [31:0]      demand_clock_sum, demand_clock_sum_next;
  logic [31:0]      queue_read_count, queue_read_count_next;

  // Queue write controls
  logic             we_lo, we_hi;
  logic [IDX_W-1:0] addr_lo, addr_hi;

  // Executed result
  logic             status_next;
  logic [7:0]       read_byte_next;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] free_next;
  logic [31:0]      fill_ext, free_ext;
  logic [31:0]      txn_clocks;
  logic [SUM_W-1:0] tail_pos;

  assign advance    = !result_valid || result_ready;
  assign exec       = in_full && advance;
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  // Command execution
  assign free_count = CNT_W'(QUEUE_DEPTH) - fill_count;
  assign tail_pos   = SUM_W'(head_index) + SUM_W'(fill_count);
  assign addr_lo    = wrap_slot(tail_pos);
  assign addr_hi    = wrap_slot(tail_pos + SUM_W'(1));
  assign txn_clocks = pfq_pkg::BUS_BASE_CLOCKS + 32'(in_q.bus_waits);

  always_comb begin
    head_index_next       = head_index;
    fill_count_next       = fill_count;
    fetch_address_next    = fetch_address;
    flush_mark_next       = flush_mark;
    txn_count_next        = txn_count;
    wait_sum_next         = wait_sum;
    active_clock_sum_next = active_clock_sum;
    demand_txn_count_next = demand_txn_count;
    demand_clock_sum_next = demand_clock_sum;
    queue_read_count_next = queue_read_count;
    status_next           = pfq_pkg::STATUS_OK;
    read_byte_next        = 8'd0;
    we_lo                 = 1'b0;
    we_hi                 = 1'b0;
    unique case (in_q.cmd)
      pfq_pkg::CMD_ENQ_BYTE: begin
        if (fill_count >= CNT_W'(QUEUE_DEPTH)) begin
          status_next = pfq_pkg::STATUS_INVALID;
        end else begin
          we_lo              = 1'b1;
          fill_count_next    = fill_count + CNT_W'(1);
          fetch_address_next = fetch_address + 16'd1;
        end
      end
      pfq_pkg::CMD_ENQ_WORD: begin
        if (free_count < CNT_W'(pfq_pkg::WORD_BYTES)) begin
          status_next = pfq_pkg::STATUS_INVALID;
        end else begin
          we_lo              = 1'b1;
          we_hi              = 1'b1;
          fill_count_next    = fill_count + CNT_W'(pfq_pkg::WORD_BYTES);
          fetch_address_next = fetch_address + 16'(pfq_pkg::WORD_BYTES);
        end
      end
      pfq_pkg::CMD_DEQ_BYTE: begin
        if (fill_count == '0) begin
          status_next = pfq_pkg::STATUS_INVALID;
        end else begin
          read_byte_next        = queue_bytes[head_index];
          head_index_next       = wrap_slot(SUM_W'(head_index) + SUM_W'(1));
          fill_count_next       = fill_count - CNT_W'(1);
          queue_read_count_next = queue_read_count + 32'd1;
        end
      end
      pfq_pkg::CMD_FLUSH: begin
        head_index_next    = '0;
        fill_count_next    = '0;
        fetch_address_next = in_q.data;
        flush_mark_next    = 1'b1;
      end
      pfq_pkg::CMD_BOUNDARY: begin
        txn_count_next        = '0;
        wait_sum_next         = '0;
        active_clock_sum_next = '0;
        demand_txn_count_next = '0;
        demand_clock_sum_next = '0;
        queue_read_count_next = '0;
        flush_mark_next       = 1'b0;
      end
      pfq_pkg::CMD_RECORD: begin
        if (in_q.txn_ok) begin
          txn_count_next        = txn_count + 32'd1;
          wait_sum_next         = wait_sum + 32'(in_q.bus_waits);
          active_clock_sum_next = active_clock_sum + txn_clocks;
          if (in_q.demand) begin
            demand_txn_count_next = demand_txn_count + 32'd1;
            demand_clock_sum_next = demand_clock_sum + txn_clocks;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign free_next = CNT_W'(QUEUE_DEPTH) - fill_count_next;
  assign fill_ext  = 32'(fill_count_next);
  assign free_ext  = 32'(free_next);

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index       <= '0;
      fill_count       <= '0;
      fetch_address    <= '0;
      flush_mark       <= 1'b0;
      txn_count        <= '0;
      wait_sum         <= '0;
      active_clock_sum <= '0;
      demand_txn_count <= '0;
      demand_clock_sum <= '0;
      queue_read_count <= '0;
    end else if (exec) begin
      head_index       <= head_index_next;
      fill_count       <= fill_count_next;
      fetch_address    <= fetch_address_next;
      flush_mark       <= flush_mark_next;
      txn_count        <= txn_count_next;
      wait_sum         <= wait_sum_next;
      active_clock_sum <= active_clock_sum_next;
      demand_txn_count <= demand_txn_count_next;
      demand_clock_sum <= demand_clock_sum_next;
      queue_read_count <= queue_read_count_next;
    end
  end

  // Queue storage, low byte first for words
  always_ff @(posedge clk) begin
    if (exec && we_lo) begin
      queue_bytes[addr_lo] <= in_q.data[7:0];
    end
    if (exec && we_hi) begin
      queue_bytes[addr_hi] <= in_q.data[15:8];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      result.status              <= status_next;
      result.read_byte           <= read_byte_next;
      result.queue_count         <= fill_ext[2:0];
      result.free_bytes          <= free_ext[2:0];
      result.fetch_ptr           <= fetch_address_next;
      result.flushed             <= flush_mark_next;
      result.bus_transactions    <= txn_count_next;
      result.wait_state_total    <= wait_sum_next;
      result.bus_active_clocks   <= active_clock_sum_next;
      result.demand_transactions <= demand_txn_count_next;
      result.demand_bus_clocks   <= demand_clock_sum_next;
      result.queue_reads         <= queue_read_count_next;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    32'(head_index) < 32'(QUEUE_DEPTH))
    else $error("head index outside the ring");

  a_fail_zero_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> result.read_byte == 8'd0)
    else $error("failed command returned a nonzero byte");

  a_deq_counts: assert property (@(posedge clk) disable iff (rst)
    exec && in_q.cmd == pfq_pkg::CMD_DEQ_BYTE && fill_count != '0
    |=> queue_read_count == $past(queue_read_count) + 32'd1
        && fill_count == $past(fill_count) - CNT_W'(1))
    else $error("dequeue did not update read count and fill");

endmodule

`default_nettype wire
